>>> hdl/fas_pkg.sv
package fas_pkg;

    localparam int DENOM_BITS_DEF    = 24;
    localparam int OUT_FRAC_BITS_DEF = 17;

    localparam int NUM_W    = 32;
    localparam int QUOT_W   = 30;
    localparam int INT_FRAC = 30;
    localparam int X_W      = 30;
    localparam int TERM_W   = 31;
    localparam int STEPS    = 7;

    localparam logic [TERM_W-1:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [32:0]       TWOPI_Q30 = 33'd6746518852;

    localparam int unsigned SIN_DIVS [0:5] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIVS [0:6] = '{182, 132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [X_W-1:0] x2;
        logic [2:0]     oct;
    } t_lane;

endpackage

>>> hdl/fas_div_cell.sv
module fas_div_cell #(
    parameter int REM_W  = 25,
    parameter int ACC_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ACC_W-1:0]  i_acc,
    input  logic [SIDE_W-1:0] i_side,
    input  logic [REM_W-1:0]  i_div,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem,
    output logic [ACC_W-1:0]  o_acc,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [ACC_W-1:0]  r_acc;
    logic [SIDE_W-1:0] r_side;
    logic [REM_W-1:0]  shifted;
    logic              ge;
    logic [REM_W-1:0]  n_rem;
    logic [ACC_W-1:0]  n_acc;

    // one restoring step: shift in next dividend bit, quotient bit out at lsb
    always_comb begin
        shifted = {i_rem[REM_W-2:0], i_acc[ACC_W-1]};
        ge      = shifted >= i_div;
        n_rem   = ge ? shifted - i_div : shifted;
        n_acc   = {i_acc[ACC_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

>>> hdl/fas_horner_cell.sv
module fas_horner_cell #(
    parameter int unsigned DIV_S  = 6,
    parameter int unsigned DIV_C  = 2,
    parameter bit          SIN_ON = 1'b1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  fas_pkg::t_lane               i_lane,
    input  logic [fas_pkg::TERM_W-1:0]   i_ts,
    input  logic [fas_pkg::TERM_W-1:0]   i_tc,
    output logic                         o_valid,
    output fas_pkg::t_lane               o_lane,
    output logic [fas_pkg::TERM_W-1:0]   o_ts,
    output logic [fas_pkg::TERM_W-1:0]   o_tc
);
    import fas_pkg::*;

    localparam logic [32:0] Two32  = 33'h1_0000_0000;
    localparam logic [31:0] RecipS = 32'(Two32 / 33'(DIV_S));
    localparam logic [31:0] RecipC = 32'(Two32 / 33'(DIV_C));
    localparam logic [31:0] HalfS  = 32'(DIV_S / 2);
    localparam logic [31:0] HalfC  = 32'(DIV_C / 2);
    localparam logic [60:0] RndQ   = 61'h2000_0000;

    logic [3:0]  r_valid;
    t_lane       r_lane1, r_lane2, r_lane3, r_lane4;
    logic [60:0] r_ps, r_pc;
    logic [31:0] r_vs, r_vc;
    logic [31:0] r_vs3, r_vc3;
    logic [63:0] r_ms, r_mc;
    logic [TERM_W-1:0] r_ts, r_tc;

    logic [60:0] rs, rc;
    logic [31:0] q0s, q0c;
    logic [39:0] rems, remc;
    logic [31:0] qs, qc;

    always_comb begin
        rs   = r_ps + RndQ;
        rc   = r_pc + RndQ;
        q0s  = r_ms[63:32];
        q0c  = r_mc[63:32];
        rems = {8'b0, r_vs3} - ({8'b0, q0s} * 40'(DIV_S));
        remc = {8'b0, r_vc3} - ({8'b0, q0c} * 40'(DIV_C));
        qs   = q0s + 32'(rems >= 40'(DIV_S));
        qc   = q0c + 32'(remc >= 40'(DIV_C));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane1 <= i_lane;
            r_ps    <= 61'(i_lane.x2) * 61'(i_ts);
            r_pc    <= 61'(i_lane.x2) * 61'(i_tc);
            r_lane2 <= r_lane1;
            r_vs    <= 32'(rs[60:INT_FRAC]) + HalfS;
            r_vc    <= 32'(rc[60:INT_FRAC]) + HalfC;
            r_lane3 <= r_lane2;
            r_vs3   <= r_vs;
            r_vc3   <= r_vc;
            r_ms    <= 64'(r_vs) * 64'(RecipS);
            r_mc    <= 64'(r_vc) * 64'(RecipC);
            r_lane4 <= r_lane3;
            r_ts    <= SIN_ON ? ONE_Q30 - TERM_W'(qs) : ONE_Q30;
            r_tc    <= ONE_Q30 - TERM_W'(qc);
        end
    end

    assign o_valid = r_valid[3];
    assign o_lane  = r_lane4;
    assign o_ts    = r_ts;
    assign o_tc    = r_tc;

endmodule

>>> hdl/fractional_angle_sincos_top.sv
// Sine and cosine of 2*pi*numerator/denominator as signed Q1.OUT_FRAC_BITS values.
// One transaction is taken every cycle while o_stall is low; each result passes
// through 32 modulo cells, sign fix, octant fold, 30 division cells, four stages
// for angle scaling and squaring, seven four-stage series cells, two rounding
// stages and the output register. A held result stalls the row only once the
// last stage is full. The denominator register resets to 1, a value of zero
// acts as one, and it must be written only while the block is empty.
module fractional_angle_sincos_top #(
    parameter int DENOM_BITS    = fas_pkg::DENOM_BITS_DEF,
    parameter int OUT_FRAC_BITS = fas_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [DENOM_BITS-1:0]        i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [31:0]           i_numerator,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [OUT_FRAC_BITS+1:0] o_sine,
    output logic signed [OUT_FRAC_BITS+1:0] o_cosine
);
    import fas_pkg::*;

    localparam int DB = DENOM_BITS;
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int Sh = INT_FRAC - OUT_FRAC_BITS;
    localparam int NW = DB + 32;

    logic [DB-1:0] r_denom;
    logic [DB-1:0] n_eff;
    logic          en;
    logic          out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_denom <= DB'(1);
        end else if (i_cfg_wr_en) begin
            r_denom <= i_cfg_wr_data;
        end
    end

    assign n_eff = (r_denom == '0) ? DB'(1) : r_denom;

    // modulo chain
    logic          mval  [0:NUM_W];
    logic [DB:0]   mrem  [0:NUM_W];
    logic [NUM_W-1:0] macc [0:NUM_W];
    logic [0:0]    msign [0:NUM_W];

    assign mval[0]  = i_valid;
    assign mrem[0]  = '0;
    assign macc[0]  = i_numerator[31] ? NUM_W'(-i_numerator) : NUM_W'(i_numerator);
    assign msign[0] = i_numerator[31];

    for (genvar g = 0; g < NUM_W; g++) begin : g_mod
        fas_div_cell #(.REM_W(DB + 1), .ACC_W(NUM_W), .SIDE_W(1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (mval[g]),
            .i_rem   (mrem[g]),
            .i_acc   (macc[g]),
            .i_side  (msign[g]),
            .i_div   ({1'b0, n_eff}),
            .o_valid (mval[g+1]),
            .o_rem   (mrem[g+1]),
            .o_acc   (macc[g+1]),
            .o_side  (msign[g+1])
        );
    end

    // sign fix
    logic          r_fx_valid;
    logic [DB-1:0] r_fx_r;
    logic [DB-1:0] mr;

    assign mr = mrem[NUM_W][DB-1:0];

    // octant fold
    logic [DB+1:0] pos0, bign, n2, p1, p2, p3;
    logic          c1, c2, c3;
    logic [NW-1:0] num;

    always_comb begin
        pos0 = {r_fx_r, 2'b00};
        bign = {n_eff, 2'b00};
        n2   = {2'b00, n_eff};
        c1   = pos0 > (bign - pos0);
        p1   = c1 ? bign - pos0 : pos0;
        c2   = p1 > n2;
        p2   = c2 ? p1 - n2 : p1;
        c3   = p2 > (n2 - p2);
        p3   = c3 ? n2 - p2 : p2;
        num  = {p3[DB-1:0], 32'b0} + NW'({n_eff, 1'b0});
    end

    logic              r_fd_valid;
    logic [DB+2:0]     r_fd_rem;
    logic [QUOT_W-1:0] r_fd_acc;
    logic [2:0]        r_fd_oct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx_valid <= 1'b0;
            r_fd_valid <= 1'b0;
        end else if (en) begin
            r_fx_valid <= mval[NUM_W];
            r_fd_valid <= r_fx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx_r   <= (msign[NUM_W][0] && mr != '0) ? n_eff - mr : mr;
            r_fd_rem <= {1'b0, num[NW-1:QUOT_W]};
            r_fd_acc <= num[QUOT_W-1:0];
            r_fd_oct <= {c1, c2, c3};
        end
    end

    // fraction-of-turn division chain
    logic              dval [0:QUOT_W];
    logic [DB+2:0]     drem [0:QUOT_W];
    logic [QUOT_W-1:0] dacc [0:QUOT_W];
    logic [2:0]        doct [0:QUOT_W];

    assign dval[0] = r_fd_valid;
    assign drem[0] = r_fd_rem;
    assign dacc[0] = r_fd_acc;
    assign doct[0] = r_fd_oct;

    for (genvar g = 0; g < QUOT_W; g++) begin : g_div
        fas_div_cell #(.REM_W(DB + 3), .ACC_W(QUOT_W), .SIDE_W(3)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dval[g]),
            .i_rem   (drem[g]),
            .i_acc   (dacc[g]),
            .i_side  (doct[g]),
            .i_div   ({1'b0, n_eff, 2'b00}),
            .o_valid (dval[g+1]),
            .o_rem   (drem[g+1]),
            .o_acc   (dacc[g+1]),
            .o_side  (doct[g+1])
        );
    end

    // angle scaling and square
    logic [QUOT_W-1:0] q;
    logic [3:0]        r_t_valid;
    logic [48:0]       r_t1_lo;
    logic [46:0]       r_t1_hi;
    logic [2:0]        r_t1_oct, r_t2_oct, r_t3_oct;
    logic [X_W-1:0]    r_t2_x, r_t3_x;
    logic [59:0]       r_t3_xx;
    t_lane             r_t4_lane;
    logic [63:0]       tsum;
    logic [60:0]       xxr;

    assign q = dacc[QUOT_W];

    always_comb begin
        tsum = {1'b0, r_t1_hi, 16'b0} + 64'(r_t1_lo) + 64'h8000_0000;
        xxr  = 61'(r_t3_xx) + 61'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= '0;
        end else if (en) begin
            r_t_valid <= {r_t_valid[2:0], dval[QUOT_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_lo       <= 49'(q[15:0]) * 49'(TWOPI_Q30);
            r_t1_hi       <= 47'(q[29:16]) * 47'(TWOPI_Q30);
            r_t1_oct      <= doct[QUOT_W];
            r_t2_x        <= tsum[61:32];
            r_t2_oct      <= r_t1_oct;
            r_t3_xx       <= 60'(r_t2_x) * 60'(r_t2_x);
            r_t3_x        <= r_t2_x;
            r_t3_oct      <= r_t2_oct;
            r_t4_lane.x   <= r_t3_x;
            r_t4_lane.x2  <= xxr[59:30];
            r_t4_lane.oct <= r_t3_oct;
        end
    end

    // series cells
    logic              hval  [0:STEPS];
    t_lane             hlane [0:STEPS];
    logic [TERM_W-1:0] hts   [0:STEPS];
    logic [TERM_W-1:0] htc   [0:STEPS];

    assign hval[0]  = r_t_valid[3];
    assign hlane[0] = r_t4_lane;
    assign hts[0]   = ONE_Q30;
    assign htc[0]   = ONE_Q30;

    for (genvar g = 0; g < STEPS; g++) begin : g_ser
        fas_horner_cell #(
            .DIV_S  ((g == 0) ? SIN_DIVS[0] : SIN_DIVS[(g == 0) ? 0 : g - 1]),
            .DIV_C  (COS_DIVS[g]),
            .SIN_ON (g != 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (hval[g]),
            .i_lane  (hlane[g]),
            .i_ts    (hts[g]),
            .i_tc    (htc[g]),
            .o_valid (hval[g+1]),
            .o_lane  (hlane[g+1]),
            .o_ts    (hts[g+1]),
            .o_tc    (htc[g+1])
        );
    end

    // final product and rounding
    logic              r_f1_valid, r_f2_valid;
    logic [60:0]       r_f1_sp;
    logic [TERM_W-1:0] r_f1_c;
    logic [2:0]        r_f1_oct, r_f2_oct;
    logic [OW-1:0]     r_f2_s, r_f2_c;
    logic [60:0]       spr;
    logic [TERM_W-1:0] s30;
    logic [OW-1:0]     so, co;

    always_comb begin
        spr = r_f1_sp + 61'h2000_0000;
        s30 = spr[60:30];
    end

    if (Sh == 0) begin : g_nosh
        assign so = OW'(s30);
        assign co = OW'(r_f1_c);
    end else begin : g_sh
        logic [TERM_W:0] srnd, crnd;
        assign srnd = {1'b0, s30} + (TERM_W+1)'(1 << (Sh - 1));
        assign crnd = {1'b0, r_f1_c} + (TERM_W+1)'(1 << (Sh - 1));
        assign so   = OW'(srnd >> Sh);
        assign co   = OW'(crnd >> Sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= hval[STEPS];
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_sp  <= 61'(hlane[STEPS].x) * 61'(hts[STEPS]);
            r_f1_c   <= htc[STEPS];
            r_f1_oct <= hlane[STEPS].oct;
            r_f2_s   <= so;
            r_f2_c   <= co;
            r_f2_oct <= r_f1_oct;
        end
    end

    // octant unfold and output register
    logic [OW-1:0] us, uc, tmp;
    logic          r_out_valid;
    logic [OW-1:0] r_out_s, r_out_c;

    always_comb begin
        us  = r_f2_s;
        uc  = r_f2_c;
        tmp = '0;
        if (r_f2_oct[0]) begin
            tmp = us;
            us  = uc;
            uc  = tmp;
        end
        if (r_f2_oct[1]) begin
            tmp = us;
            us  = uc;
            uc  = -tmp;
        end
        if (r_f2_oct[2]) begin
            us = -us;
        end
    end

    assign out_take = !r_out_valid || !i_stall;
    assign en       = !(r_f2_valid && r_out_valid && i_stall);
    assign o_stall  = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_s <= us;
            r_out_c <= uc;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sine   = r_out_s;
    assign o_cosine = r_out_c;

endmodule

>>> verif/fractional_angle_sincos_top_tb.sv
`timescale 1ns / 100ps
module fractional_angle_sincos_top_tb;

    localparam int DENOM_W  = fas_pkg::DENOM_BITS_DEF;
    localparam int FRAC_W   = fas_pkg::OUT_FRAC_BITS_DEF;
    localparam int OUT_W    = FRAC_W + 2;
    localparam int DRAIN    = 120;
    localparam int LIMIT    = 400000;
    localparam int LONG_HOLD = 500;
    localparam logic signed [OUT_W-1:0] ONE_OUT = 1 <<< FRAC_W;

    typedef struct {
        int unsigned         denom;
        logic signed [31:0]  num;
        bit                  typed;
        logic signed [OUT_W-1:0] sin_v;
        logic signed [OUT_W-1:0] cos_v;
    } t_row;

    typedef struct {
        logic signed [OUT_W-1:0] sin_v;
        logic signed [OUT_W-1:0] cos_v;
    } t_pair;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [DENOM_W-1:0]      i_cfg_wr_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [31:0]      i_numerator = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_sine;
    logic signed [OUT_W-1:0] o_cosine;

    t_pair       pending_pairs[$];
    int unsigned cur_denom = 1;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    bit          hold_request = 1'b0;
    int          hold_count = 0;
    int          errors = 0;
    int          cycles = 0;

    fractional_angle_sincos_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_numerator   (i_numerator),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sine        (o_sine),
        .o_cosine      (o_cosine)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned taylor_sum(longint unsigned x2, bit is_cos);
        longint unsigned sin_div[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cos_div[7] = '{182, 132, 90, 56, 30, 12, 2};
        longint unsigned t = 64'd1 << 30;
        longint unsigned d;
        int cnt = is_cos ? 7 : 6;
        for (int i = 0; i < cnt; i++) begin
            d = is_cos ? cos_div[i] : sin_div[i];
            t = (64'd1 << 30) - (q30_mul(x2, t) + d / 2) / d;
        end
        return t;
    endfunction

    function automatic t_pair angle_sincos(logic signed [31:0] num, int unsigned denom);
        longint unsigned n = (denom & 32'hFF_FFFF) == 0 ? 1 : (denom & 32'hFF_FFFF);
        longint m = num;
        longint r;
        longint unsigned big_n, pos, q, x, x2, s, c, t;
        logic [2:0] oct = 3'b000;
        t_pair res;
        r = m % longint'(n);
        if (r < 0) r += n;
        big_n = n << 2;
        pos = longint'(r) << 2;
        if (pos > big_n - pos) begin pos = big_n - pos; oct[2] = 1'b1; end
        if (pos > n) begin pos = pos - n; oct[1] = 1'b1; end
        if (pos > n - pos) begin pos = n - pos; oct[0] = 1'b1; end
        q = ((pos << 32) + (big_n >> 1)) / big_n;
        x = (q * 64'd6746518852 + (64'd1 << 31)) >> 32;
        x2 = q30_mul(x, x);
        s = (q30_mul(x, taylor_sum(x2, 1'b0)) + (64'd1 << 12)) >> 13;
        c = (taylor_sum(x2, 1'b1) + (64'd1 << 12)) >> 13;
        if (oct[0]) begin t = c; c = s; s = t; end
        if (oct[1]) begin t = c; c = 64'd0 - s; s = t; end
        if (oct[2]) s = 64'd0 - s;
        res.sin_v = s[OUT_W-1:0];
        res.cos_v = c[OUT_W-1:0];
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_denom(int unsigned value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[DENOM_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_denom = value & 32'hFF_FFFF;
    endtask

    task automatic send_numerator(logic signed [31:0] num, bit typed, t_pair typed_pair);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_numerator <= num;
        do @(posedge i_clk); while (o_stall);
        pending_pairs.push_back(typed ? typed_pair : angle_sincos(num, cur_denom));
    endtask

    function automatic logic signed [31:0] pick_numerator(int unsigned denom);
        longint n = (denom == 0) ? 1 : denom;
        longint k;
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                k = longint'($urandom_range(0, 64)) * n / 8 + $urandom_range(0, 2) - 1;
                return $urandom_range(1) ? -k : k;
            end
            2: return $urandom_range(0, denom * 2 + 1);
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000 + $urandom_range(0, 3);
                    1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
                    2: return -$urandom_range(0, 4);
                    default: return $urandom_range(0, 4);
                endcase
            end
        endcase
    endfunction

    // receiver side: random stalls plus one long hold
    always @(posedge i_clk) begin
        if (hold_request && hold_count == 0) begin
            hold_count <= LONG_HOLD;
            hold_request <= 1'b0;
            i_stall <= 1'b1;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pair want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected transaction sine %0d cosine %0d",
                         $time, o_sine, o_cosine);
                errors++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_sine !== want.sin_v) begin
                    $display("%0t: sine expected %0d actual %0d", $time, want.sin_v, o_sine);
                    errors++;
                end
                if (o_cosine !== want.cos_v) begin
                    $display("%0t: cosine expected %0d actual %0d",
                             $time, want.cos_v, o_cosine);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("%0t: timeout, %0d transactions outstanding", $time, pending_pairs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    t_row directed[] = '{
        '{1,        32'sd0,          1, 0, ONE_OUT},
        '{1,        32'h8000_0000,   1, 0, ONE_OUT},
        '{1,        32'h7FFF_FFFF,   1, 0, ONE_OUT},
        '{1,        -32'sd1,         1, 0, ONE_OUT},
        '{4,        32'sd1,          1, ONE_OUT, 0},
        '{4,        32'sd2,          1, 0, -ONE_OUT},
        '{4,        -32'sd1,         0, 0, 0},
        '{4,        32'sd3,          0, 0, 0},
        '{8,        32'sd1,          0, 0, 0},
        '{8,        32'sd5,          0, 0, 0},
        '{8,        32'h8000_0000,   0, 0, 0},
        '{0,        32'sd12345,      1, 0, ONE_OUT},
        '{0,        32'h8000_0000,   1, 0, ONE_OUT},
        '{16777215, 32'sd0,          1, 0, ONE_OUT},
        '{16777215, 32'sd2097151,    0, 0, 0},
        '{16777215, 32'sd2097152,    0, 0, 0},
        '{16777215, 32'sd16777214,   0, 0, 0},
        '{16777215, 32'h7FFF_FFFF,   0, 0, 0},
        '{16777215, 32'h8000_0000,   0, 0, 0},
        '{16777215, -32'sd8388608,   0, 0, 0}
    };

    int unsigned phase_denoms[] = '{7, 16777215, 3, 360, 1000003, 0, 12, 1, 65536};

    initial begin
        t_pair typed_pair;
        int unsigned d;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].denom != cur_denom) begin
                i_valid <= 1'b0;
                write_denom(directed[i].denom);
            end
            typed_pair.sin_v = directed[i].sin_v;
            typed_pair.cos_v = directed[i].cos_v;
            send_numerator(directed[i].num, directed[i].typed, typed_pair);
        end

        for (int p = 0; p <= phase_denoms.size(); p++) begin
            d = (p == phase_denoms.size()) ? $urandom_range(1, 16777215) : phase_denoms[p];
            i_valid <= 1'b0;
            write_denom(d);
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
                default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
            endcase
            if (p == 4) hold_request = 1'b1;
            for (int k = 0; k < 55; k++) begin
                if (p == 6 && k == 30) begin
                    i_valid <= 1'b0;
                    while (pending_pairs.size() != 0) @(posedge i_clk);
                end
                send_numerator(pick_numerator(cur_denom), 1'b0, typed_pair);
            end
        end
        i_valid <= 1'b0;
        wait_drained();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/fas_pkg.sv
hdl/fas_div_cell.sv
hdl/fas_horner_cell.sv
hdl/fractional_angle_sincos_top.sv
verif/fractional_angle_sincos_top_tb.sv
